/* rtl/rcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcd_pkg;

    // Fixed width of the prime registers and of all modular values.
    localparam int unsigned MOD_W = 16;

    typedef struct packed {
        logic [31:0] ciphertext_word;
        logic        last_item;
    } t_in;

    typedef struct packed {
        logic [7:0] plaintext_byte;
        logic       last_out;
    } t_out;

    typedef enum logic [1:0] {
        OP_RED = 2'd0,  // 32-bit value reduced mod dv
        OP_DIV = 2'd1,  // 16-bit divide by dv, quotient times a folded mod md
        OP_MUL = 2'd2   // a * x[31:16] mod md
    } t_mu_op;

    typedef struct packed {
        t_mu_op           op;
        logic [31:0]      x;
        logic [MOD_W-1:0] a;
        logic [MOD_W-1:0] dv;
        logic [MOD_W-1:0] md;
    } t_mu_req;

    localparam logic [1:0] CFG_PRIME_P = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q = 2'd1;
    localparam logic [1:0] CFG_PRIV_D  = 2'd2;

endpackage

`default_nettype wire

/* rtl/rcd_serial_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module rcd_serial_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire rcd_pkg::t_mu_req i_req,
    output logic                  o_done,
    output logic [15:0]           o_rem,
    output logic [15:0]           o_macc
);
    import rcd_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    t_mu_op           r_op;
    logic [31:0]      r_x;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_macc;
    logic [MOD_W-1:0] r_a;
    logic [MOD_W-1:0] r_dv;
    logic [MOD_W-1:0] r_md;

    logic             bit_in;
    logic [MOD_W:0]   t_rem;
    logic             ge;
    logic [MOD_W:0]   n_rem;
    logic [MOD_W:0]   s_dbl;
    logic [MOD_W:0]   s_red;
    logic             sel;
    logic [MOD_W:0]   u_sum;
    logic [MOD_W:0]   n_macc;

    // one dividend / multiplier bit per cycle, MSB first
    always_comb begin
        bit_in = r_x[31];
        t_rem  = {r_rem, bit_in};
        ge     = (t_rem >= {1'b0, r_dv});
        n_rem  = ge ? (t_rem - {1'b0, r_dv}) : t_rem;
        s_dbl  = {r_macc, 1'b0};
        s_red  = (s_dbl >= {1'b0, r_md}) ? (s_dbl - {1'b0, r_md}) : s_dbl;
        sel    = (r_op == OP_MUL) ? bit_in : ge;
        u_sum  = s_red + (sel ? {1'b0, r_a} : '0);
        n_macc = (u_sum >= {1'b0, r_md}) ? (u_sum - {1'b0, r_md}) : u_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == OP_RED) ? 6'd32 : 6'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_req.op;
            r_x    <= i_req.x;
            r_a    <= i_req.a;
            r_dv   <= i_req.dv;
            r_md   <= i_req.md;
            r_rem  <= '0;
            r_macc <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[30:0], 1'b0};
            r_rem  <= n_rem[MOD_W-1:0];
            r_macc <= n_macc[MOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_macc = r_macc;

endmodule

`default_nettype wire

/* rtl/rsa_crt_decrypt_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// RSA decryption by the Chinese remainder theorem. Each input transaction carries one
// 32-bit ciphertext word; each output transaction carries the low byte of the
// recovered message and a copy of the last flag. Primes p, q and exponent d are to be
// written through the register port only while the core is idle; the core does not
// enforce this. Any write of p, q or d drops the cached key, and the next transaction
// first derives dP = d mod (p-1), dQ = d mod (q-1) and qInv = q^-1 mod p (three
// 32-bit reductions, then extended Euclid with one division step per iteration,
// up to about 23 iterations).
// The reductions, divides and modular multiplies run through one bit-serial unit that
// handles one bit per cycle. A transaction takes three reductions and the multiply
// for h, plus one square per exponent bit and one multiply per set bit over two
// 16-bit exponents, all through that single unit. The input is taken only while
// the core is idle; the finished result sits in an output register, so a new
// transaction may start while it still waits to be taken.
// Primes below two give a plaintext byte of zero.
module rsa_crt_decrypt_core #(
    parameter int unsigned PRIME_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire rcd_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output rcd_pkg::t_out       o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);
    import rcd_pkg::*;

    localparam logic [MOD_W-1:0] PMASK = (PRIME_BITS >= MOD_W) ? {MOD_W{1'b1}} :
        MOD_W'((32'd1 << PRIME_BITS) - 32'd1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DP   = 12'b000000000010,
        S_DQ   = 12'b000000000100,
        S_QR   = 12'b000000001000,
        S_INV  = 12'b000000010000,
        S_CP   = 12'b000000100000,
        S_CQ   = 12'b000001000000,
        S_SQ   = 12'b000010000000,
        S_ML   = 12'b000100000000,
        S_M2R  = 12'b001000000000,
        S_H    = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    t_state           r_state;
    logic             r_issued;
    logic             r_key_ok;
    logic [MOD_W-1:0] r_p, r_q;
    logic [31:0]      r_d;
    logic [MOD_W-1:0] r_dp, r_dq, r_qinv;
    logic [31:0]      r_c;
    logic             r_last;
    logic [MOD_W-1:0] r_cp, r_cq, r_m1, r_m2, r_acc, r_diff;
    logic [MOD_W-1:0] r_e;
    logic [3:0]       r_ecnt;
    logic             r_phase;   // 0: exponent mod p, 1: mod q
    logic [MOD_W-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [7:0]       r_byte;
    logic             r_out_valid;
    t_out             r_out;

    logic             in_acc;
    logic             mu_start;
    t_mu_req          mu_req;
    logic             mu_done;
    logic [MOD_W-1:0] mu_rem, mu_macc;
    logic             work;
    logic [MOD_W-1:0] md_exp, base_exp;
    logic [MOD_W:0]   tn_w, diff_w;
    logic [7:0]       hq;
    logic             keys_bad;
    logic             out_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign keys_bad   = (r_p < MOD_W'(2)) || (r_q < MOD_W'(2));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign md_exp     = r_phase ? r_q : r_p;
    assign base_exp   = r_phase ? r_cq : r_cp;

    always_comb begin
        mu_req = '{op: OP_RED, x: '0, a: '0, dv: r_p, md: r_p};
        work   = 1'b0;
        unique case (r_state)
            S_DP:  begin work = 1'b1; mu_req.x = r_d; mu_req.dv = r_p - MOD_W'(1); end
            S_DQ:  begin work = 1'b1; mu_req.x = r_d; mu_req.dv = r_q - MOD_W'(1); end
            S_QR:  begin work = 1'b1; mu_req.x = {16'd0, r_q}; end
            S_INV: begin
                work       = (r_r1 != '0);
                mu_req.op  = OP_DIV;
                mu_req.x   = {r_r0, 16'd0};
                mu_req.a   = r_t1;
                mu_req.dv  = r_r1;
            end
            S_CP:  begin work = 1'b1; mu_req.x = r_c; end
            S_CQ:  begin work = 1'b1; mu_req.x = r_c; mu_req.dv = r_q; end
            S_SQ:  begin
                work      = 1'b1;
                mu_req.op = OP_MUL;
                mu_req.x  = {r_acc, 16'd0};
                mu_req.a  = r_acc;
                mu_req.md = md_exp;
                mu_req.dv = md_exp;
            end
            S_ML:  begin
                work      = 1'b1;
                mu_req.op = OP_MUL;
                mu_req.x  = {base_exp, 16'd0};
                mu_req.a  = r_acc;
                mu_req.md = md_exp;
                mu_req.dv = md_exp;
            end
            S_M2R: begin work = 1'b1; mu_req.x = {16'd0, r_m2}; end
            S_H:   begin
                work      = 1'b1;
                mu_req.op = OP_MUL;
                mu_req.x  = {r_diff, 16'd0};
                mu_req.a  = r_qinv;
            end
            default: work = 1'b0;
        endcase
    end

    assign mu_start = work && !r_issued;

    rcd_serial_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mu_start),
        .i_req   (mu_req),
        .o_done  (mu_done),
        .o_rem   (mu_rem),
        .o_macc  (mu_macc)
    );

    // Euclid coefficient update and CRT difference, both mod p
    assign tn_w = (r_t0 >= mu_macc) ? ({1'b0, r_t0} - {1'b0, mu_macc})
                                    : ({1'b0, r_t0} + {1'b0, r_p} - {1'b0, mu_macc});
    assign diff_w = (r_m1 >= mu_rem) ? ({1'b0, r_m1} - {1'b0, mu_rem})
                                     : ({1'b0, r_m1} + {1'b0, r_p} - {1'b0, mu_rem});
    // only the low byte of m2 + h*q is needed
    assign hq = mu_macc[7:0] * r_q[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_key_ok    <= 1'b0;
            r_p         <= MOD_W'(3);
            r_q         <= MOD_W'(5);
            r_d         <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (mu_start) begin
                r_issued <= 1'b1;
            end
            if (mu_done) begin
                r_issued <= 1'b0;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PRIME_P: begin r_p <= i_cfg_data[15:0] & PMASK; r_key_ok <= 1'b0; end
                    CFG_PRIME_Q: begin r_q <= i_cfg_data[15:0] & PMASK; r_key_ok <= 1'b0; end
                    CFG_PRIV_D:  begin r_d <= i_cfg_data; r_key_ok <= 1'b0; end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_c    <= i_in_data.ciphertext_word;
                        r_last <= i_in_data.last_item;
                        if (keys_bad) begin
                            r_byte  <= 8'd0;
                            r_state <= S_OUT;
                        end else if (!r_key_ok) begin
                            r_state <= S_DP;
                        end else begin
                            r_state <= S_CP;
                        end
                    end
                end
                S_DP: if (mu_done) begin
                    r_dp    <= mu_rem;
                    r_state <= S_DQ;
                end
                S_DQ: if (mu_done) begin
                    r_dq    <= mu_rem;
                    r_state <= S_QR;
                end
                S_QR: if (mu_done) begin
                    r_r0    <= r_p;
                    r_r1    <= mu_rem;
                    r_t0    <= '0;
                    r_t1    <= MOD_W'(1);
                    r_state <= S_INV;
                end
                S_INV: begin
                    if (r_r1 == '0) begin
                        r_qinv   <= (r_r0 == MOD_W'(1)) ? r_t0 : '0;
                        r_key_ok <= 1'b1;
                        r_state  <= S_CP;
                    end else if (mu_done) begin
                        r_r0 <= r_r1;
                        r_r1 <= mu_rem;
                        r_t0 <= r_t1;
                        r_t1 <= tn_w[MOD_W-1:0];
                    end
                end
                S_CP: if (mu_done) begin
                    r_cp    <= mu_rem;
                    r_state <= S_CQ;
                end
                S_CQ: if (mu_done) begin
                    r_cq    <= mu_rem;
                    r_e     <= r_dp;
                    r_ecnt  <= 4'd15;
                    r_acc   <= MOD_W'(1);
                    r_phase <= 1'b0;
                    r_state <= S_SQ;
                end
                S_SQ, S_ML: if (mu_done) begin
                    r_acc <= mu_macc;
                    if (r_state == S_SQ && r_e[MOD_W-1]) begin
                        r_state <= S_ML;
                    end else begin
                        r_e    <= {r_e[MOD_W-2:0], 1'b0};
                        r_ecnt <= r_ecnt - 4'd1;
                        if (r_ecnt != 4'd0) begin
                            r_state <= S_SQ;
                        end else if (!r_phase) begin
                            r_m1    <= mu_macc;
                            r_e     <= r_dq;
                            r_ecnt  <= 4'd15;
                            r_acc   <= MOD_W'(1);
                            r_phase <= 1'b1;
                            r_state <= S_SQ;
                        end else begin
                            r_m2    <= mu_macc;
                            r_state <= S_M2R;
                        end
                    end
                end
                S_M2R: if (mu_done) begin
                    r_diff  <= diff_w[MOD_W-1:0];
                    r_state <= S_H;
                end
                S_H: if (mu_done) begin
                    r_byte  <= r_m2[7:0] + hq;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{plaintext_byte: r_byte, last_out: r_last};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the serial unit only reports completion of work it was given
    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mu_done |-> r_issued)
        else $error("serial unit done without a request");

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("transaction accepted but core stayed idle");

    // a result appears only out of the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid raised outside the output state");

endmodule

`default_nettype wire

/* test/rsa_crt_checker.sv */
`timescale 1ns / 1ps

module rsa_crt_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rcd_pkg::t_in        i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rcd_pkg::t_out       i_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import rcd_pkg::*;

    logic [15:0] key_p, key_q;
    logic [31:0] key_d;
    logic [15:0] exp_p, exp_q, qinv;
    logic        key_ok;
    t_out        plain_queue[$];

    assign o_pending = plain_queue.size();

    function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 1 % m;
        sq  = b % m;
        while (e != 0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_inv(logic [63:0] a, logic [63:0] m);
        longint r0, r1, t0, t1, quo, rn, tn;
        r0 = longint'(m);
        r1 = longint'(a % m);
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            quo = r0 / r1;
            rn  = r0 - quo * r1;
            tn  = t0 - quo * t1;
            r0 = r1; r1 = rn;
            t0 = t1; t1 = tn;
        end
        if (r0 != 1) return 0;
        t0 = t0 % longint'(m);
        if (t0 < 0) t0 += longint'(m);
        return t0;
    endfunction

    function automatic t_out decrypt_word(t_in x);
        t_out r;
        logic [63:0] p, q, m1, m2, diff, h, m;
        p = key_p;
        q = key_q;
        m = 0;
        if (!key_ok) begin
            if (p >= 2 && q >= 2) begin
                exp_p = 16'(key_d % (p - 1));
                exp_q = 16'(key_d % (q - 1));
                qinv  = 16'(mod_inv(q, p));
            end else begin
                exp_p = 0; exp_q = 0; qinv = 0;
            end
            key_ok = 1'b1;
        end
        if (p >= 2 && q >= 2) begin
            m1   = mod_pow(x.ciphertext_word % p, exp_p, p);
            m2   = mod_pow(x.ciphertext_word % q, exp_q, q);
            diff = (m1 + p - (m2 % p)) % p;
            h    = (qinv * diff) % p;
            m    = m2 + h * q;
        end
        r.plaintext_byte = m[7:0];
        r.last_out       = x.last_item;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            key_p = 16'd3; key_q = 16'd5; key_d = 32'd1;
            exp_p = 0; exp_q = 0; qinv = 0; key_ok = 1'b0;
            plain_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRIME_P: begin key_p = i_cfg_data[15:0]; key_ok = 1'b0; end
                    CFG_PRIME_Q: begin key_q = i_cfg_data[15:0]; key_ok = 1'b0; end
                    CFG_PRIV_D:  begin key_d = i_cfg_data;       key_ok = 1'b0; end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                plain_queue.push_back(decrypt_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (plain_queue.size() == 0) begin
                    report_mismatch("unexpected output transaction");
                end else begin
                    e = plain_queue.pop_front();
                    if (i_out_data.plaintext_byte !== e.plaintext_byte)
                        report_mismatch($sformatf("plaintext_byte %h, want %h",
                            i_out_data.plaintext_byte, e.plaintext_byte));
                    if (i_out_data.last_out !== e.last_out)
                        report_mismatch($sformatf("last_out %b, want %b",
                            i_out_data.last_out, e.last_out));
                end
            end
        end
    end

    // leftovers are counted by the top via o_pending
endmodule

/* test/tb_rsa_crt_decrypt_core.sv */
`timescale 1ns / 1ps

module tb_rsa_crt_decrypt_core;
    import rcd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    rsa_crt_decrypt_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    rsa_crt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random
    always @(posedge i_clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // one transaction: random idle gap, then hold until accepted; the core
    // stalls straight after taking one, so the trailing wait costs nothing
    task automatic send_word(logic [31:0] c, logic last);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_valid <= 1'b1;
        in_data  <= '{ciphertext_word: c, last_item: last};
        do @(posedge i_clk); while (in_stall);
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // register write only once everything has drained, plus settling time
    task automatic write_key(logic [1:0] idx, logic [31:0] val);
        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_key(logic [15:0] p, logic [15:0] q, logic [31:0] d);
        write_key(CFG_PRIME_P, {16'h0, p});
        write_key(CFG_PRIME_Q, {16'h0, q});
        write_key(CFG_PRIV_D, d);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0:       return $urandom_range(255);
            1:       return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    // small prime list keeps real decryptions in the mix
    logic [15:0] primes[12] = '{16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd61,
                                16'd53, 16'd251, 16'd257, 16'd4093, 16'd65521,
                                16'd65519};

    initial begin
        logic [15:0] rp, rq;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset key, then the extremes and special cases
        send_word(32'd0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'd14, 1'b0);
        load_key(16'd61, 16'd53, 32'd2753);
        send_word(32'd2790, 1'b0);
        send_word(32'd65, 1'b1);
        load_key(16'd65521, 16'd65519, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0001, 1'b1);
        write_key(CFG_PRIME_P, 32'd1);          // prime below two
        send_word(32'd1234, 1'b1);
        write_key(CFG_PRIME_P, 32'd0);
        send_word(32'd99, 1'b0);
        load_key(16'd7, 16'd7, 32'd5);          // no inverse
        send_word(32'd20, 1'b1);
        load_key(16'd11, 16'd13, 32'd10);       // exponent zero for p side
        send_word(32'd77, 1'b0);
        load_key(16'd15, 16'd21, 32'd7);        // composite moduli
        send_word(32'd300, 1'b1);
        write_key(2'd3, 32'hFFFF_FFFF);         // index beyond the list
        send_word(32'd5, 1'b0);
        load_key(16'hFFFF, 16'hFFFE, 32'h0);
        send_word(32'h0001_0000, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(4) == 0) begin
                    rp = 16'($urandom_range(65535));
                    rq = 16'($urandom_range(65535));
                end else begin
                    rp = primes[$urandom_range(11)];
                    rq = primes[$urandom_range(11)];
                end
                load_key(rp, rq, $urandom_range(3) == 0 ? $urandom_range(15) : $urandom);
                for (int n = 0; n < 31; n++)
                    send_word(rand_word(), 1'($urandom_range(1)));
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (1300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
